// ===== hdl/epws_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// epws_pkg
// Shared types and codes of the serial EEPROM page write sequencer.
// ----------------------------------------------------------------------------
package epws_pkg;

    // event codes of an input item
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_DONE  = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    // sequencer modes
    localparam logic [2:0] MODE_STOPPED = 3'd0;
    localparam logic [2:0] MODE_READING = 3'd1;
    localparam logic [2:0] MODE_WRITING = 3'd2;
    localparam logic [2:0] MODE_WAITACK = 3'd3;
    localparam logic [2:0] MODE_FAILED  = 3'd4;

    // bus operations
    localparam logic [1:0] BUS_NONE  = 2'd0;
    localparam logic [1:0] BUS_READ  = 2'd1;
    localparam logic [1:0] BUS_WRITE = 2'd2;
    localparam logic [1:0] BUS_POLL  = 2'd3;

    // caller notices
    localparam logic [1:0] NOTE_NONE = 2'd0;
    localparam logic [1:0] NOTE_OK   = 2'd1;
    localparam logic [1:0] NOTE_FAIL = 2'd2;

    // device byte base
    localparam logic [7:0] DEV_BASE = 8'hA0;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  device_select;
        logic [15:0] address;
        logic [15:0] length;
        logic        notify_wanted;
        logic        trx_ok;
        logic        bus_accepts;
    } t_item;

    typedef struct packed {
        logic        accepted;
        logic [1:0]  bus_op;
        logic [7:0]  bus_device;
        logic [15:0] bus_address;
        logic [15:0] bus_length;
        logic [15:0] buffer_offset;
        logic [1:0]  notify;
        logic [2:0]  engine_mode;
    } t_result;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] write_pointer;
        logic [15:0] bytes_remaining;
        logic [2:0]  chip_select;
        logic [15:0] data_offset;
        logic        polling_on;
        logic        notice_pending;
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/epws_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// epws_step
// Next-state and result logic for one event of the page write sequencer.
// ----------------------------------------------------------------------------
module epws_step #(
    parameter int PAGE_BYTES        = 64,
    parameter int MAX_WRITE_ADDRESS = 32767,
    parameter int PW                = $clog2(PAGE_BYTES + 1),
    parameter int OW                = $clog2(PAGE_BYTES),
    parameter int RW                = $clog2(65536 / PAGE_BYTES + 1)
) (
    input  var epws_pkg::t_item   i_item,
    input  var logic [RW-1:0]     i_quot,
    input  var epws_pkg::t_state  i_state,
    input  var logic [OW-1:0]     i_page_off,
    output epws_pkg::t_state      o_state,
    output logic [OW-1:0]         o_page_off,
    output epws_pkg::t_result     o_result
);
    import epws_pkg::*;

    // offset correction when the write pointer wraps at 16 bits
    localparam int WRAP_ADJ = (PAGE_BYTES - (65536 % PAGE_BYTES)) % PAGE_BYTES;

    logic [RW+PW-1:0] qp;
    logic [15:0]      rem_raw;
    logic [PW:0]      rem2;
    logic [PW:0]      rem_red;
    logic [OW-1:0]    addr_rem;
    logic             is_wr;
    logic [15:0]      c_wp;
    logic [15:0]      c_len;
    logic [15:0]      c_doff;
    logic [OW-1:0]    c_off;
    logic [PW-1:0]    room;
    logic [PW-1:0]    n_cap;
    logic [PW-1:0]    n_chunk;
    logic [16:0]      wp_sum;
    logic [PW:0]      off_sum;
    logic [PW:0]      off_red;
    logic             run_chunk;

    // address modulo page size, quotient estimate comes from the input stage
    always_comb begin
        qp       = {{PW{1'b0}}, i_quot} * (RW+PW)'(PAGE_BYTES);
        rem_raw  = i_item.address - qp[15:0];
        rem2     = rem_raw[PW:0];
        rem_red  = (rem2 >= (PW+1)'(PAGE_BYTES)) ? rem2 - (PW+1)'(PAGE_BYTES) : rem2;
        addr_rem = rem_red[OW-1:0];
    end

    // chunk operands: fresh request or the running write
    assign is_wr  = (i_item.command == CMD_WRITE);
    assign c_wp   = is_wr ? i_item.address : i_state.write_pointer;
    assign c_len  = is_wr ? i_item.length  : i_state.bytes_remaining;
    assign c_doff = is_wr ? 16'd0          : i_state.data_offset;
    assign c_off  = is_wr ? addr_rem       : i_page_off;

    // chunk size: at most one page, never across a page boundary
    always_comb begin
        room    = PW'(PAGE_BYTES) - PW'(c_off);
        n_cap   = (c_len > 16'(PAGE_BYTES)) ? PW'(PAGE_BYTES) : c_len[PW-1:0];
        n_chunk = (n_cap > room) ? room : n_cap;
        wp_sum  = {1'b0, c_wp} + 17'(n_chunk);
        off_sum = (PW+1)'(c_off) + (PW+1)'(n_chunk)
                + (wp_sum[16] ? (PW+1)'(WRAP_ADJ) : (PW+1)'(0));
        off_red = (off_sum >= (PW+1)'(PAGE_BYTES)) ?
                  off_sum - (PW+1)'(PAGE_BYTES) : off_sum;
    end

    // event decode
    always_comb begin
        o_state    = i_state;
        o_page_off = i_page_off;
        o_result   = '0;
        run_chunk  = 1'b0;
        case (i_item.command)
            CMD_READ: begin
                if (i_state.mode == MODE_STOPPED) begin
                    o_state.mode           = MODE_READING;
                    o_state.notice_pending = i_item.notify_wanted;
                    o_result.bus_op        = BUS_READ;
                    o_result.bus_device    = DEV_BASE | {5'd0, i_item.device_select};
                    o_result.bus_address   = i_item.address;
                    o_result.bus_length    = i_item.length;
                    if (i_item.bus_accepts) begin
                        o_result.accepted = 1'b1;
                    end else begin
                        o_state.mode = MODE_STOPPED;
                    end
                end
            end
            CMD_WRITE: begin
                if (i_state.mode == MODE_STOPPED) begin
                    o_state.chip_select = i_item.device_select;
                    if (i_item.address <= 16'(MAX_WRITE_ADDRESS)) begin
                        o_state.write_pointer   = i_item.address;
                        o_state.bytes_remaining = i_item.length;
                        o_state.data_offset     = 16'd0;
                        o_state.notice_pending  = i_item.notify_wanted;
                        o_page_off              = addr_rem;
                        run_chunk               = 1'b1;
                    end
                end
            end
            CMD_DONE: begin
                if (!i_item.trx_ok) begin
                    if (i_state.mode != MODE_WAITACK) begin
                        o_state.mode = MODE_FAILED;
                        if (i_state.notice_pending) begin
                            o_result.notify = NOTE_FAIL;
                        end
                        o_state.notice_pending = 1'b0;
                    end
                end else begin
                    case (i_state.mode)
                        MODE_READING: begin
                            if (i_state.notice_pending) begin
                                o_result.notify = NOTE_OK;
                            end
                            o_state.notice_pending = 1'b0;
                            o_state.mode           = MODE_STOPPED;
                        end
                        MODE_WRITING: begin
                            o_state.mode       = MODE_WAITACK;
                            o_state.polling_on = 1'b1;
                        end
                        MODE_WAITACK: begin
                            run_chunk = 1'b1;
                        end
                        MODE_FAILED: begin
                            o_state.mode = MODE_STOPPED;
                        end
                        default: begin
                            o_state.mode = MODE_FAILED;
                        end
                    endcase
                end
            end
            default: begin
                if (i_state.polling_on &&
                    (i_state.mode == MODE_WAITACK || i_state.mode == MODE_FAILED)) begin
                    o_result.bus_op     = BUS_POLL;
                    o_result.bus_device = DEV_BASE;
                end
            end
        endcase

        // start next chunk or finish the write
        if (run_chunk) begin
            if (c_len == 16'd0) begin
                o_state.polling_on = 1'b0;
                o_state.mode       = MODE_STOPPED;
                if (o_state.notice_pending) begin
                    o_result.notify = NOTE_OK;
                end
                o_state.notice_pending = 1'b0;
                o_result.accepted      = 1'b1;
            end else begin
                o_state.mode           = MODE_WRITING;
                o_result.bus_op        = BUS_WRITE;
                o_result.bus_device    = DEV_BASE | {5'd0, o_state.chip_select};
                o_result.bus_address   = c_wp;
                o_result.bus_length    = 16'(n_chunk);
                o_result.buffer_offset = c_doff;
                if (!i_item.bus_accepts) begin
                    o_state.mode = MODE_FAILED;
                end else begin
                    o_state.bytes_remaining = c_len - 16'(n_chunk);
                    o_state.write_pointer   = wp_sum[15:0];
                    o_state.data_offset     = c_doff + 16'(n_chunk);
                    o_page_off              = off_red[OW-1:0];
                    o_result.accepted       = 1'b1;
                end
            end
        end

        o_result.engine_mode = o_state.mode;
    end

endmodule
`default_nettype wire

// ===== hdl/eeprom_page_write_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eeprom_page_write_sequencer
// Page write and acknowledge polling sequencer for a two-wire serial EEPROM.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one event per item: a read
// or write request, a bus completion report or a poll tick. Output channel
// (o_out_valid / i_out_ready) returns exactly one result item per event: the
// bus transaction to start, the caller notice and the mode after the event.
// Writes are cut into chunks of at most PAGE_BYTES that stay within a page;
// after each chunk the device is polled on ticks until it acknowledges.
// An accepted item passes through the input register, where the page
// quotient of the address is estimated by a reciprocal multiply, and then
// through the decode logic into the result register. One item per cycle is
// sustained while the receiver does not stall; the sequencer state updates as
// an item moves into the result register, so consecutive items chain.
// Reset clears both pipeline stages and puts the sequencer in the stopped
// mode with all counters at zero. When the receiver stalls, the result is
// held, the input register still takes one more item, and o_in_ready drops.
// ----------------------------------------------------------------------------
module eeprom_page_write_sequencer #(
    parameter int PAGE_BYTES        = 64,
    parameter int MAX_WRITE_ADDRESS = 32767
) (
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    input  var logic        i_in_valid,
    output logic            o_in_ready,
    input  var logic [1:0]  i_command,
    input  var logic [2:0]  i_device_select,
    input  var logic [15:0] i_address,
    input  var logic [15:0] i_length,
    input  var logic        i_notify_wanted,
    input  var logic        i_trx_ok,
    input  var logic        i_bus_accepts,
    output logic            o_out_valid,
    input  var logic        i_out_ready,
    output logic            o_accepted,
    output logic [1:0]      o_bus_op,
    output logic [7:0]      o_bus_device,
    output logic [15:0]     o_bus_address,
    output logic [15:0]     o_bus_length,
    output logic [15:0]     o_buffer_offset,
    output logic [1:0]      o_notify,
    output logic [2:0]      o_engine_mode
);
    import epws_pkg::*;

    localparam int PW    = $clog2(PAGE_BYTES + 1);
    localparam int OW    = $clog2(PAGE_BYTES);
    localparam int RECIP = 65536 / PAGE_BYTES;
    localparam int RW    = $clog2(RECIP + 1);

    logic             r_in_valid;
    t_item            r_item;
    logic [RW-1:0]    r_quot;
    logic             r_out_valid;
    t_result          r_res;
    t_state           r_state;
    logic [OW-1:0]    r_page_off;

    t_state           n_state;
    logic [OW-1:0]    n_page_off;
    t_result          n_res;
    logic [16+RW-1:0] quot_prod;
    logic             advance;

    // pipeline handshake
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // page quotient estimate of the incoming address
    assign quot_prod = {{RW{1'b0}}, i_address} * (16+RW)'(RECIP);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_item.command       <= i_command;
            r_item.device_select <= i_device_select;
            r_item.address       <= i_address;
            r_item.length        <= i_length;
            r_item.notify_wanted <= i_notify_wanted;
            r_item.trx_ok        <= i_trx_ok;
            r_item.bus_accepts   <= i_bus_accepts;
            r_quot               <= quot_prod[16+RW-1:16];
        end
    end

    // event decode
    epws_step #(
        .PAGE_BYTES        (PAGE_BYTES),
        .MAX_WRITE_ADDRESS (MAX_WRITE_ADDRESS),
        .PW                (PW),
        .OW                (OW),
        .RW                (RW)
    ) u_step (
        .i_item     (r_item),
        .i_quot     (r_quot),
        .i_state    (r_state),
        .i_page_off (r_page_off),
        .o_state    (n_state),
        .o_page_off (n_page_off),
        .o_result   (n_res)
    );

    // sequencer state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '{mode: MODE_STOPPED, default: '0};
            r_page_off  <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_page_off  <= n_page_off;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    // result ports
    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_res.accepted;
    assign o_bus_op        = r_res.bus_op;
    assign o_bus_device    = r_res.bus_device;
    assign o_bus_address   = r_res.bus_address;
    assign o_bus_length    = r_res.bus_length;
    assign o_buffer_offset = r_res.buffer_offset;
    assign o_notify        = r_res.notify;
    assign o_engine_mode   = r_res.engine_mode;

endmodule
`default_nettype wire

// ===== tb/eeprom_page_write_sequencer_test.sv =====
// ----------------------------------------------------------------------------
// eeprom_page_write_sequencer_test
// Self-checking bench for the page write sequencer. A driver feeds events
// from a queue, in bursts with random gaps. A shadow copy of the sequencer
// predicts one result item per accepted event. A monitor with its own stall
// pattern compares every result field by field. Directed events cover the
// limits and corner cases. Random read and write sessions with chunking,
// polling, refusals and noise follow.
// ----------------------------------------------------------------------------
module eeprom_page_write_sequencer_test;

    import epws_pkg::*;

    localparam int unsigned PAGE_SIZE   = 64;
    localparam int unsigned MAX_WRITE   = 32767;
    localparam int          RANDOM_ITEMS = 1000;
    localparam int          CYCLE_LIMIT  = 300000;

    typedef struct {
        t_item ev;
        bit    hold;    // wait for all results before this item
    } t_pending;

    typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_SLOW, RX_PERIODIC} t_rx_kind;

    // clock, reset and block ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_command = CMD_TICK;
    logic [2:0]  i_device_select = 3'd0;
    logic [15:0] i_address = 16'd0;
    logic [15:0] i_length = 16'd0;
    logic        i_notify_wanted = 1'b0;
    logic        i_trx_ok = 1'b0;
    logic        i_bus_accepts = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_accepted;
    logic [1:0]  o_bus_op;
    logic [7:0]  o_bus_device;
    logic [15:0] o_bus_address;
    logic [15:0] o_bus_length;
    logic [15:0] o_buffer_offset;
    logic [1:0]  o_notify;
    logic [2:0]  o_engine_mode;

    // queues and bookkeeping
    t_pending pending_events[$];
    t_result  predicted_results[$];
    t_state   shadow;
    t_item    on_wire;
    t_pending next_up;
    t_result  oldest;
    int       queued_total = 0;
    bit       hold_next = 1'b0;
    int       mismatch_count = 0;
    int       cycle_count = 0;
    int       burst_left = 8;
    int       gap_left = 0;
    int       stall_span = 0;
    int       phase_cnt = 0;
    t_rx_kind stall_kind = RX_STREAM;

    eeprom_page_write_sequencer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_device_select (i_device_select),
        .i_address       (i_address),
        .i_length        (i_length),
        .i_notify_wanted (i_notify_wanted),
        .i_trx_ok        (i_trx_ok),
        .i_bus_accepts   (i_bus_accepts),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_accepted      (o_accepted),
        .o_bus_op        (o_bus_op),
        .o_bus_device    (o_bus_device),
        .o_bus_address   (o_bus_address),
        .o_bus_length    (o_bus_length),
        .o_buffer_offset (o_buffer_offset),
        .o_notify        (o_notify),
        .o_engine_mode   (o_engine_mode)
    );

    always begin
        #5 i_clk = ~i_clk;
    end

    // caller notice goes out only if one is pending, and is then consumed
    function automatic void send_notice(inout t_result r, input logic [1:0] code);
        if (shadow.notice_pending) r.notify = code;
        shadow.notice_pending = 1'b0;
    endfunction

    // start the next page-bounded chunk, or close out the write when nothing is left
    function automatic logic launch_chunk(inout t_result r, input logic bus_ok);
        int unsigned n;
        int unsigned room;
        n = 32'(shadow.bytes_remaining);
        if (n > PAGE_SIZE) n = PAGE_SIZE;
        if (n == 0) begin
            shadow.polling_on = 1'b0;
            shadow.mode = MODE_STOPPED;
            send_notice(r, NOTE_OK);
            return 1'b1;
        end
        room = PAGE_SIZE - (shadow.write_pointer % PAGE_SIZE);
        if (n > room) n = room;
        shadow.mode     = MODE_WRITING;
        r.bus_op        = BUS_WRITE;
        r.bus_device    = DEV_BASE | {5'd0, shadow.chip_select};
        r.bus_address   = shadow.write_pointer;
        r.bus_length    = n[15:0];
        r.buffer_offset = shadow.data_offset;
        if (!bus_ok) begin
            shadow.mode = MODE_FAILED;
            return 1'b0;
        end
        shadow.bytes_remaining = shadow.bytes_remaining - n[15:0];
        shadow.write_pointer   = shadow.write_pointer + n[15:0];
        shadow.data_offset     = shadow.data_offset + n[15:0];
        return 1'b1;
    endfunction

    // expected result item of one event, advancing the shadow state
    function automatic t_result predict_event(input t_item it);
        t_result r;
        r = '0;
        case (it.command)
            CMD_READ: begin
                if (shadow.mode == MODE_STOPPED) begin
                    shadow.mode = MODE_READING;
                    shadow.notice_pending = it.notify_wanted;
                    r.bus_op      = BUS_READ;
                    r.bus_device  = DEV_BASE | {5'd0, it.device_select};
                    r.bus_address = it.address;
                    r.bus_length  = it.length;
                    if (it.bus_accepts) r.accepted = 1'b1;
                    else shadow.mode = MODE_STOPPED;
                end
            end
            CMD_WRITE: begin
                if (shadow.mode == MODE_STOPPED) begin
                    shadow.chip_select = it.device_select;
                    if (it.address <= MAX_WRITE) begin
                        shadow.write_pointer   = it.address;
                        shadow.bytes_remaining = it.length;
                        shadow.data_offset     = 16'd0;
                        shadow.notice_pending  = it.notify_wanted;
                        r.accepted = launch_chunk(r, it.bus_accepts);
                    end
                end
            end
            CMD_DONE: begin
                if (!it.trx_ok) begin
                    // a failed report is ignored while waiting for the acknowledge
                    if (shadow.mode != MODE_WAITACK) begin
                        shadow.mode = MODE_FAILED;
                        send_notice(r, NOTE_FAIL);
                    end
                end else if (shadow.mode == MODE_READING) begin
                    send_notice(r, NOTE_OK);
                    shadow.mode = MODE_STOPPED;
                end else if (shadow.mode == MODE_WRITING) begin
                    shadow.mode = MODE_WAITACK;
                    shadow.polling_on = 1'b1;
                end else if (shadow.mode == MODE_WAITACK) begin
                    r.accepted = launch_chunk(r, it.bus_accepts);
                end else if (shadow.mode == MODE_FAILED) begin
                    shadow.mode = MODE_STOPPED;
                end else begin
                    shadow.mode = MODE_FAILED;
                end
            end
            default: begin
                if (shadow.polling_on &&
                    (shadow.mode == MODE_WAITACK || shadow.mode == MODE_FAILED)) begin
                    r.bus_op     = BUS_POLL;
                    r.bus_device = DEV_BASE;
                end
            end
        endcase
        r.engine_mode = shadow.mode;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0h, actual %0h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    task automatic queue_event(input logic [1:0] cmd, input logic [2:0] sel,
                               input logic [15:0] addr, input logic [15:0] len,
                               input logic want, input logic ok, input logic bus);
        t_pending p;
        p.ev.command       = cmd;
        p.ev.device_select = sel;
        p.ev.address       = addr;
        p.ev.length        = len;
        p.ev.notify_wanted = want;
        p.ev.trx_ok        = ok;
        p.ev.bus_accepts   = bus;
        p.hold             = hold_next;
        hold_next          = 1'b0;
        pending_events.push_back(p);
        queued_total++;
    endtask

    // completion report with the unused fields scrambled
    task automatic queue_done(input logic ok, input logic bus);
        queue_event(CMD_DONE, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), ok, bus);
    endtask

    task automatic queue_tick();
        queue_event(CMD_TICK, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // driver: bursts of items with random gaps, prediction on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predicted_results.push_back(predict_event(on_wire));
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_events.size() != 0 &&
                             !(pending_events[0].hold && predicted_results.size() != 0)) begin
                    next_up = pending_events.pop_front();
                    on_wire = next_up.ev;
                    i_in_valid      <= 1'b1;
                    i_command       <= on_wire.command;
                    i_device_select <= on_wire.device_select;
                    i_address       <= on_wire.address;
                    i_length        <= on_wire.length;
                    i_notify_wanted <= on_wire.notify_wanted;
                    i_trx_ok        <= on_wire.trx_ok;
                    i_bus_accepts   <= on_wire.bus_accepts;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result item, then drive the stall pattern
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            if (predicted_results.size() == 0) begin
                $display("%0t: result with nothing expected, actual op %0d mode %0d",
                         $time, o_bus_op, o_engine_mode);
                mismatch_count++;
            end else begin
                oldest = predicted_results.pop_front();
                check_field("accepted", 16'(oldest.accepted), 16'(o_accepted));
                check_field("bus_op", 16'(oldest.bus_op), 16'(o_bus_op));
                check_field("bus_device", 16'(oldest.bus_device), 16'(o_bus_device));
                check_field("bus_address", oldest.bus_address, o_bus_address);
                check_field("bus_length", oldest.bus_length, o_bus_length);
                check_field("buffer_offset", oldest.buffer_offset, o_buffer_offset);
                check_field("notify", 16'(oldest.notify), 16'(o_notify));
                check_field("engine_mode", 16'(oldest.engine_mode), 16'(o_engine_mode));
            end
        end
        if (stall_span == 0) begin
            stall_kind = t_rx_kind'($urandom_range(0, 3));
            stall_span = $urandom_range(40, 400);
        end else begin
            stall_span--;
        end
        phase_cnt++;
        case (stall_kind)
            RX_STREAM:   i_out_ready <= 1'b1;
            RX_RANDOM:   i_out_ready <= ($urandom_range(0, 3) != 0);
            RX_SLOW:     i_out_ready <= ($urandom_range(0, 3) == 0);
            default:     i_out_ready <= ((phase_cnt % 7) < 3);
        endcase
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // stimulus, reset and end of run
    initial begin
        int          choice;
        int          k;
        int          chunks;
        int          next_hold;
        bit          in_chunks;
        logic [15:0] addr;
        logic [15:0] len;
        logic [15:0] ptr;
        logic [15:0] rem;
        logic [15:0] n;
        logic        bus;
        logic        ok;

        shadow = '0;
        shadow.mode = MODE_STOPPED;

        // directed: address limit, zero length, refusals, polls, failure paths
        queue_event(CMD_WRITE, 3'd7, 16'h8000, 16'd5, 1'b1, 1'b1, 1'b1);
        queue_event(CMD_WRITE, 3'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        queue_event(CMD_WRITE, 3'd3, 16'h7FF0, 16'd0, 1'b1, 1'b0, 1'b0);
        queue_event(CMD_READ, 3'd7, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b1);
        queue_event(CMD_READ, 3'd1, 16'h1234, 16'd9, 1'b0, 1'b1, 1'b1);
        queue_done(1'b1, 1'b1);
        queue_event(CMD_READ, 3'd0, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0);
        queue_done(1'b1, 1'b1);
        queue_tick();
        queue_done(1'b0, 1'b1);
        queue_done(1'b1, 1'b0);
        // one byte up to the limit, then the rest past it into the next page
        queue_event(CMD_WRITE, 3'd5, 16'h7FFF, 16'd3, 1'b1, 1'b0, 1'b1);
        queue_event(CMD_WRITE, 3'd2, 16'h0010, 16'd4, 1'b0, 1'b1, 1'b1);
        queue_done(1'b1, 1'b0);
        queue_tick();
        queue_done(1'b0, 1'b0);
        queue_done(1'b1, 1'b1);
        queue_done(1'b1, 1'b0);
        queue_done(1'b1, 1'b1);
        // chunk refused after an acknowledge, polls while failed
        queue_event(CMD_WRITE, 3'd2, 16'h0040, 16'd100, 1'b1, 1'b1, 1'b1);
        queue_done(1'b1, 1'b1);
        queue_done(1'b1, 1'b0);
        queue_tick();
        queue_done(1'b0, 1'b1);
        queue_done(1'b1, 1'b1);
        // longest write, failed mid transfer
        queue_event(CMD_WRITE, 3'd1, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1);
        queue_done(1'b0, 1'b1);
        queue_done(1'b1, 1'b1);

        // random sessions, draining everything now and then
        next_hold = queued_total;
        while (queued_total < next_hold + RANDOM_ITEMS - 150 * ((queued_total - next_hold) / 150)
               && queued_total < 28 + RANDOM_ITEMS) begin
            if (queued_total >= next_hold) begin
                hold_next = 1'b1;
                next_hold = queued_total + 150;
            end
            choice = $urandom_range(0, 99);
            if (choice < 55) begin
                // write session: request, chunk cycles with polling, completion
                k = $urandom_range(0, 9);
                if (k == 0) addr = 16'($urandom_range(32768, 65535));
                else if (k < 5) addr = 16'($urandom_range(0, MAX_WRITE));
                else addr = 16'($urandom_range(1, 512) * PAGE_SIZE - $urandom_range(1, 8));
                k = $urandom_range(0, 99);
                if (k < 5) len = 16'd0;
                else if (k < 8) len = 16'($urandom_range(0, 65535));
                else len = 16'($urandom_range(1, 200));
                bus = ($urandom_range(0, 19) != 0);
                queue_event(CMD_WRITE, 3'($urandom_range(0, 7)), addr, len,
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), bus);
                if (addr <= MAX_WRITE && len != 0) begin
                    if (!bus) begin
                        repeat ($urandom_range(0, 2)) queue_tick();
                        queue_done(1'b1, 1'($urandom_range(0, 1)));
                    end else begin
                        ptr = addr;
                        rem = len;
                        chunks = 0;
                        in_chunks = 1'b1;
                        while (in_chunks) begin
                            n = 16'((rem > PAGE_SIZE) ? PAGE_SIZE : rem);
                            if (n > PAGE_SIZE - ptr % PAGE_SIZE)
                                n = 16'(PAGE_SIZE - ptr % PAGE_SIZE);
                            ptr = ptr + n;
                            rem = rem - n;
                            chunks++;
                            if ($urandom_range(0, 24) == 0) begin
                                // chunk transfer fails on the bus
                                queue_done(1'b0, 1'($urandom_range(0, 1)));
                                queue_done(1'b1, 1'($urandom_range(0, 1)));
                                in_chunks = 1'b0;
                            end else begin
                                queue_done(1'b1, 1'($urandom_range(0, 1)));
                                repeat ($urandom_range(0, 3)) begin
                                    if ($urandom_range(0, 4) == 0)
                                        queue_done(1'b0, 1'($urandom_range(0, 1)));
                                    else
                                        queue_tick();
                                end
                                if (rem == 0) begin
                                    queue_done(1'b1, 1'($urandom_range(0, 1)));
                                    in_chunks = 1'b0;
                                end else if (chunks == 8) begin
                                    // cut a long write short by refusing the next chunk
                                    queue_done(1'b1, 1'b0);
                                    queue_tick();
                                    queue_done(1'b1, 1'b1);
                                    in_chunks = 1'b0;
                                end else begin
                                    bus = ($urandom_range(0, 19) != 0);
                                    queue_done(1'b1, bus);
                                    if (!bus) begin
                                        queue_tick();
                                        queue_done(1'b1, 1'b1);
                                        in_chunks = 1'b0;
                                    end
                                end
                            end
                        end
                    end
                end
            end else if (choice < 85) begin
                // read session with an occasional request while busy
                bus = ($urandom_range(0, 9) != 0);
                queue_event(CMD_READ, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), bus);
                if (bus) begin
                    if ($urandom_range(0, 9) == 0)
                        queue_event(2'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                                    16'($urandom_range(0, 65535)),
                                    16'($urandom_range(0, 65535)),
                                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)));
                    repeat ($urandom_range(0, 2)) queue_tick();
                    ok = ($urandom_range(0, 9) != 0);
                    queue_done(ok, 1'($urandom_range(0, 1)));
                    if (!ok) queue_done(1'b1, 1'($urandom_range(0, 1)));
                end
            end else begin
                // unstructured events
                repeat ($urandom_range(1, 3))
                    queue_event(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                                16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 65535)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_events.size() != 0 || i_in_valid || predicted_results.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        if (mismatch_count == 0 && predicted_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/epws_pkg.sv
hdl/epws_step.sv
hdl/eeprom_page_write_sequencer.sv
tb/eeprom_page_write_sequencer_test.sv
